>>> hdl/tab_pkg.sv
`default_nettype none

package tab_pkg;

  localparam int DEF_MAX_DIM   = 4096;
  localparam int DEF_MID_DEPTH = 2;
  localparam int DEF_OUT_DEPTH = 4;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TINT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;

  // item opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [31:0] TINT_OFF  = 32'hFFFF_FFFF;
  localparam logic [15:0] FRAC_HALF = 16'h8000;
  localparam logic [27:0] COL_RESET = 28'h000_8000;
  localparam logic [27:0] ACC_MAX   = 28'hFFF_FFFF;

  typedef struct packed {
    logic        opcode;
    logic [31:0] src_pixel;
    logic [31:0] dst_pixel;
  } in_t;

  typedef struct packed {
    logic [31:0] out_pixel;
    logic [11:0] next_src_col;
    logic [11:0] next_src_row;
    logic        row_end;
    logic        blit_end;
  } out_t;

  typedef struct packed {
    logic [31:0] tint_color;
    logic [23:0] step_x;
    logic [23:0] step_y;
    logic [12:0] blit_width;
    logic [12:0] blit_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    tint_color:  32'hFFFF_FFFF,
    step_x:      24'h01_0000,
    step_y:      24'h01_0000,
    blit_width:  13'd1,
    blit_height: 13'd1
  };

  // classified item handed from the position front end to the pixel back end
  typedef struct packed {
    logic        is_pixel;
    logic [31:0] src_pixel;
    logic [31:0] dst_pixel;
    logic [11:0] next_src_col;
    logic [11:0] next_src_row;
    logic        row_end;
    logic        blit_end;
  } job_t;

endpackage

`default_nettype wire

>>> hdl/tab_fifo.sv
`default_nettype none

module tab_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire logic [WIDTH-1:0]             wr_data_i,
  input  wire logic                         pop_i,
  output logic      [WIDTH-1:0]             rd_data_o,
  output logic                              full_o,
  output logic                              empty_o,
  output logic      [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o    = (cnt_q == CNT_W'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign count_o   = cnt_q;
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tab_front.sv
`default_nettype none

module tab_front #(
  parameter int MAX_DIM = tab_pkg::DEF_MAX_DIM
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire tab_pkg::in_t  item_i,
  input  wire tab_pkg::cfg_t cfg_i,
  output tab_pkg::job_t      job_o
);

  import tab_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int ROW_W = $clog2(MAX_DIM);
  localparam int DIM_W = (CNT_W > 13) ? CNT_W : 13;
  localparam int SUM_W = ROW_W + 10;
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(MAX_DIM - 1);
  localparam logic [SUM_W-1:0] ROW_LIM = SUM_W'(MAX_DIM - 1);
  localparam logic [11:0]      COL_MAX = 12'(MAX_DIM - 1);

  logic [27:0]      col_accum_q, col_accum_d;
  logic [15:0]      row_frac_q, row_frac_d;
  logic [ROW_W-1:0] src_row_q, src_row_d;
  logic [CNT_W-1:0] col_count_q, col_count_d;
  logic [CNT_W-1:0] row_count_q, row_count_d;

  logic [DIM_W-1:0] width_c, height_c;
  logic [28:0]      col_sum;
  logic [27:0]      col_adv;
  logic [CNT_W-1:0] col_inc, row_inc;
  logic [24:0]      frac_sum;
  logic [SUM_W-1:0] row_sum;
  logic [ROW_W-1:0] row_sat;
  logic             row_done, blit_done;
  logic [11:0]      col_int;
  logic [31:0]      row_ext;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [12:0] v);
    logic [DIM_W-1:0] w;
    w = DIM_W'(v);
    if (w == '0) begin
      return DIM_W'(1);
    end else if (w > DIM_MAX) begin
      return DIM_MAX;
    end
    return w;
  endfunction

  always_comb begin
    width_c   = clamp_dim(cfg_i.blit_width);
    height_c  = clamp_dim(cfg_i.blit_height);
    col_sum   = {1'b0, col_accum_q} + 29'(cfg_i.step_x);
    col_adv   = col_sum[28] ? ACC_MAX : col_sum[27:0];
    col_inc   = col_count_q + CNT_W'(1);
    row_inc   = row_count_q + CNT_W'(1);
    row_done  = (DIM_W'(col_inc) >= width_c);
    blit_done = (DIM_W'(row_inc) >= height_c);
    frac_sum  = 25'(row_frac_q) + 25'(cfg_i.step_y);
    row_sum   = SUM_W'(src_row_q) + SUM_W'(frac_sum[24:16]);
    row_sat   = (row_sum > ROW_LIM) ? ROW_MAX : row_sum[ROW_W-1:0];

    col_accum_d = col_accum_q;
    row_frac_d  = row_frac_q;
    src_row_d   = src_row_q;
    col_count_d = col_count_q;
    row_count_d = row_count_q;

    if (accept_i) begin
      if (item_i.opcode == OP_START) begin
        col_accum_d = COL_RESET;
        row_frac_d  = FRAC_HALF;
        src_row_d   = '0;
        col_count_d = '0;
        row_count_d = '0;
      end else begin
        col_accum_d = col_adv;
        col_count_d = col_inc;
        if (row_done) begin
          col_count_d = '0;
          col_accum_d = COL_RESET;
          row_frac_d  = frac_sum[15:0];
          src_row_d   = row_sat;
          row_count_d = row_inc;
          // last row done: back to the start-of-blit position
          if (blit_done) begin
            row_frac_d  = FRAC_HALF;
            src_row_d   = '0;
            row_count_d = '0;
          end
        end
      end
    end

    col_int = col_accum_d[27:16];
    row_ext = 32'(src_row_d);

    job_o.is_pixel     = (item_i.opcode == OP_PIXEL);
    job_o.src_pixel    = item_i.src_pixel;
    job_o.dst_pixel    = item_i.dst_pixel;
    job_o.next_src_col = (32'(col_int) > 32'(MAX_DIM - 1)) ? COL_MAX : col_int;
    job_o.next_src_row = row_ext[11:0];
    job_o.row_end      = (item_i.opcode == OP_PIXEL) && row_done;
    job_o.blit_end     = (item_i.opcode == OP_PIXEL) && row_done && blit_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_accum_q <= COL_RESET;
      row_frac_q  <= FRAC_HALF;
      src_row_q   <= '0;
      col_count_q <= '0;
      row_count_q <= '0;
    end else begin
      col_accum_q <= col_accum_d;
      row_frac_q  <= row_frac_d;
      src_row_q   <= src_row_d;
      col_count_q <= col_count_d;
      row_count_q <= row_count_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tab_back.sv
`default_nettype none

module tab_back #(
  parameter int OUT_DEPTH = tab_pkg::DEF_OUT_DEPTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             job_valid_i,
  input  wire tab_pkg::job_t                    job_i,
  output logic                                  job_pop_o,
  input  wire logic [31:0]                      tint_i,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0]   out_count_i,
  output logic                                  out_push_o,
  output tab_pkg::out_t                         out_o
);

  import tab_pkg::*;

  localparam int CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int FLY_W = CNT_W + 1;

  logic       s1_valid_q, s2_valid_q;
  job_t       s1_job_q;
  out_t       s2_out_q;
  logic [FLY_W-1:0] in_flight;

  // tint stage
  logic [15:0] tb_prod;
  logic [16:0] tg_prod, tr_prod, ta_prod;
  logic [31:0] tinted;
  job_t        s1_job_d;

  // blend stage
  logic [8:0]  alpha, ialpha;
  logic [32:0] sa, sb, da, db;
  logic [31:0] rb_sum, ag_sum, blended;
  out_t        s2_out_d;

  // items already committed to the result queue space
  assign in_flight = FLY_W'(s1_valid_q) + FLY_W'(s2_valid_q) + FLY_W'(out_count_i);
  assign job_pop_o = job_valid_i && (in_flight < FLY_W'(OUT_DEPTH));

  always_comb begin
    // blue uses the tint byte as is, the other channels tint+1
    tb_prod = job_i.src_pixel[7:0] * tint_i[7:0];
    tg_prod = job_i.src_pixel[15:8] * ({1'b0, tint_i[15:8]} + 9'd1);
    tr_prod = job_i.src_pixel[23:16] * ({1'b0, tint_i[23:16]} + 9'd1);
    ta_prod = job_i.src_pixel[31:24] * ({1'b0, tint_i[31:24]} + 9'd1);
    tinted  = {ta_prod[15:8], tr_prod[15:8], tg_prod[15:8], tb_prod[15:8]};
    s1_job_d = job_i;
    if (tint_i != TINT_OFF) begin
      s1_job_d.src_pixel = tinted;
    end
  end

  always_comb begin
    alpha = {1'b0, s1_job_q.src_pixel[31:24]};
    if (s1_job_q.src_pixel[31]) begin
      alpha = alpha + 9'd1;
    end
    ialpha = 9'h100 - alpha;
    // two lanes per product, no carry crosses a lane
    sa = {s1_job_q.src_pixel[23:16], 8'h00, s1_job_q.src_pixel[7:0]} * alpha;
    sb = {s1_job_q.src_pixel[31:24], 8'h00, s1_job_q.src_pixel[15:8]} * alpha;
    da = {s1_job_q.dst_pixel[23:16], 8'h00, s1_job_q.dst_pixel[7:0]} * ialpha;
    db = {s1_job_q.dst_pixel[31:24], 8'h00, s1_job_q.dst_pixel[15:8]} * ialpha;
    rb_sum  = sa[31:0] + da[31:0];
    ag_sum  = sb[31:0] + db[31:0];
    blended = ((rb_sum >> 8) & 32'h00FF_00FF) + (ag_sum & 32'hFF00_FF00);

    s2_out_d.out_pixel    = s1_job_q.is_pixel ? blended : '0;
    s2_out_d.next_src_col = s1_job_q.next_src_col;
    s2_out_d.next_src_row = s1_job_q.next_src_row;
    s2_out_d.row_end      = s1_job_q.row_end;
    s2_out_d.blit_end     = s1_job_q.blit_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= job_pop_o;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      s1_job_q <= s1_job_d;
    end
    if (s1_valid_q) begin
      s2_out_q <= s2_out_d;
    end
  end

  assign out_push_o = s2_valid_q;
  assign out_o      = s2_out_q;

endmodule

`default_nettype wire

>>> hdl/tinted_alpha_blit_engine.sv
// tinted alpha blit engine, per-pixel stage with nearest-neighbor scaling
//
// input queue side: push with in_data_i (opcode, src_pixel, dst_pixel); a beat
// is taken when push is high and full is low. opcode start clears the
// column/row position, opcode pixel tints, blends and advances the position.
// result queue side: while empty is low the oldest result sits on out_data_o
// (out_pixel, next_src_col, next_src_row, row_end, blit_end); pop takes it.
// config side: cfg_valid_i/cfg_ready_o with register index and data; ready is
// always high, writes are expected only while no beat is in flight.
//
// a beat taken on the input side passes the front position update into a
// small job queue, then the tint stage, the blend stage and the result queue.
// throughput is one beat per cycle while pop keeps up, set by the position
// accumulators in the front and the fully pipelined back end. reset clears
// all queues, returns the position to column 0 (accumulator 0x8000) / row 0
// and loads the register defaults. when pop stays low the result queue fills,
// the back end stops pulling jobs, the job queue fills and full goes high.
`default_nettype none

module tinted_alpha_blit_engine #(
  parameter int MAX_DIM   = tab_pkg::DEF_MAX_DIM,
  parameter int MID_DEPTH = tab_pkg::DEF_MID_DEPTH,
  parameter int OUT_DEPTH = tab_pkg::DEF_OUT_DEPTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input beats
  input  wire logic                            push,
  output logic                                 full,
  input  wire tab_pkg::in_t                    in_data_i,
  // result beats
  output logic                                 empty,
  input  wire logic                            pop,
  output tab_pkg::out_t                        out_data_o,
  // register writes
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [tab_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [31:0]                     cfg_data_i
);

  import tab_pkg::*;

  localparam int OCNT_W = $clog2(OUT_DEPTH + 1);
  localparam int MCNT_W = $clog2(MID_DEPTH + 1);

  cfg_t  cfg_q;
  logic  in_take;
  job_t  front_job, mid_job;
  logic  mid_full, mid_empty, mid_pop;
  logic  out_push, out_full;
  out_t  back_out;
  logic [OCNT_W-1:0] out_count;
  logic [MCNT_W-1:0] mid_count;
  logic  unused_out_full;
  logic  unused_mid_count;

  // register file, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_TINT:   cfg_q.tint_color  <= cfg_data_i;
        REG_STEP_X: cfg_q.step_x      <= cfg_data_i[23:0];
        REG_STEP_Y: cfg_q.step_y      <= cfg_data_i[23:0];
        REG_WIDTH:  cfg_q.blit_width  <= cfg_data_i[12:0];
        REG_HEIGHT: cfg_q.blit_height <= cfg_data_i[12:0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // front: position accumulators and row/blit end flags
  assign full    = mid_full;
  assign in_take = push && !mid_full;

  tab_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_take),
    .item_i   (in_data_i),
    .cfg_i    (cfg_q),
    .job_o    (front_job)
  );

  // decoupling queue between position front and pixel back end
  tab_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (in_take),
    .wr_data_i (front_job),
    .pop_i     (mid_pop),
    .rd_data_o (mid_job),
    .full_o    (mid_full),
    .empty_o   (mid_empty),
    .count_o   (mid_count)
  );

  // back: tint then blend, pulls only when the result queue has room
  tab_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!mid_empty),
    .job_i       (mid_job),
    .job_pop_o   (mid_pop),
    .tint_i      (cfg_q.tint_color),
    .out_count_i (out_count),
    .out_push_o  (out_push),
    .out_o       (back_out)
  );

  // result queue, never overflows thanks to the back end credit check
  tab_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (out_push),
    .wr_data_i (back_out),
    .pop_i     (pop),
    .rd_data_o (out_data_o),
    .full_o    (out_full),
    .empty_o   (empty),
    .count_o   (out_count)
  );

  // out_full only matters as a sanity term: credit keeps it from blocking a push
  assign unused_out_full  = out_full;
  // job queue occupancy is not needed, full and empty drive the handshakes
  assign unused_mid_count = ^mid_count;

endmodule

`default_nettype wire

>>> hdl/tab_checker.sv
`default_nettype none

module tab_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          empty,
  input wire logic          pop,
  input wire tab_pkg::out_t out_data_o
);

  import tab_pkg::*;

  // a blit ends only on the last pixel of a row
  a_blit_end_is_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.blit_end) |-> out_data_o.row_end)
    else $error("blit end without row end");

  // after a row end the next fetch starts at source column zero
  a_row_end_col_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.row_end) |-> (out_data_o.next_src_col == 12'd0))
    else $error("row end did not rewind the column");

  // after a blit end the next fetch is back at source row zero
  a_blit_end_row_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.blit_end) |-> (out_data_o.next_src_row == 12'd0))
    else $error("blit end did not rewind the row");

  // a waiting result stays put until it is popped
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("waiting result changed or vanished");

endmodule

bind tinted_alpha_blit_engine tab_checker u_tab_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_data_o (out_data_o)
);

`default_nettype wire

>>> verif/tab_blit_checker.sv
module tab_blit_checker
  import tab_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 full_i,
  input  in_t                  in_data_i,
  input  logic                 empty_i,
  input  logic                 pop_i,
  input  out_t                 out_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [12:0] DIM_MAX  = 13'(DEF_MAX_DIM);
  localparam logic [13:0] ROW_LAST = 14'(DEF_MAX_DIM - 1);

  cfg_t        regs;
  logic [27:0] col_acc;
  logic [15:0] row_frac;
  logic [11:0] src_row;
  logic [12:0] col_cnt;
  logic [12:0] row_cnt;
  out_t        predicted_writes[$];
  int          results_seen;

  // zero acts as one, anything past the largest frame acts as the largest
  function automatic logic [12:0] dim_limit(logic [12:0] v);
    if (v == '0) return 13'd1;
    if (v > DIM_MAX) return DIM_MAX;
    return v;
  endfunction

  // blue uses the tint byte as is, the other channels tint + 1
  function automatic logic [31:0] tint_px(logic [31:0] s, logic [31:0] t);
    logic [8:0]  m;
    logic [15:0] prod;
    logic [31:0] r;
    for (int ch = 0; ch < 4; ch++) begin
      m = (ch == 0) ? {1'b0, t[ch*8 +: 8]} : {1'b0, t[ch*8 +: 8]} + 9'd1;
      prod = s[ch*8 +: 8] * m;
      r[ch*8 +: 8] = prod[15:8];
    end
    return r;
  endfunction

  function automatic logic [31:0] blend_px(logic [31:0] s, logic [31:0] d);
    logic [8:0]  a;
    logic [8:0]  ia;
    logic [15:0] sum;
    logic [31:0] r;
    a = {1'b0, s[31:24]};
    if (s[31]) a = a + 9'd1;
    ia = 9'h100 - a;
    for (int ch = 0; ch < 4; ch++) begin
      sum = s[ch*8 +: 8] * a + d[ch*8 +: 8] * ia;
      r[ch*8 +: 8] = sum[15:8];
    end
    return r;
  endfunction

  task automatic clear_position();
    col_acc  = COL_RESET;
    row_frac = FRAC_HALF;
    src_row  = '0;
    col_cnt  = '0;
    row_cnt  = '0;
  endtask

  task automatic blit_pixel(input in_t beat);
    out_t        o;
    logic [31:0] s;
    logic [28:0] col_sum;
    logic [24:0] row_sum;
    logic [13:0] row_next;
    o = '0;
    if (beat.opcode == OP_START) begin
      clear_position();
    end else begin
      s = beat.src_pixel;
      if (regs.tint_color != TINT_OFF) s = tint_px(s, regs.tint_color);
      o.out_pixel = blend_px(s, beat.dst_pixel);
      col_sum = {1'b0, col_acc} + {5'b0, regs.step_x};
      col_acc = (col_sum > {1'b0, ACC_MAX}) ? ACC_MAX : col_sum[27:0];
      col_cnt = col_cnt + 13'd1;
      if (col_cnt >= dim_limit(regs.blit_width)) begin
        o.row_end = 1'b1;
        col_cnt   = '0;
        col_acc   = COL_RESET;
        row_sum   = {9'b0, row_frac} + {1'b0, regs.step_y};
        row_next  = {2'b0, src_row} + {5'b0, row_sum[24:16]};
        src_row   = (row_next > ROW_LAST) ? ROW_LAST[11:0] : row_next[11:0];
        row_frac  = row_sum[15:0];
        row_cnt   = row_cnt + 13'd1;
        if (row_cnt >= dim_limit(regs.blit_height)) begin
          o.blit_end = 1'b1;
          clear_position();
        end
      end
    end
    // integer part of a 28-bit accumulator never passes the last column
    o.next_src_col = col_acc[27:16];
    o.next_src_row = src_row;
    predicted_writes.push_back(o);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t  want;
    string bad;
    if (!rst_ni) begin
      regs = CFG_RESET;
      clear_position();
      predicted_writes.delete();
      fail_count_o = 0;
      results_seen = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_TINT:   regs.tint_color  = cfg_data_i;
          REG_STEP_X: regs.step_x      = cfg_data_i[23:0];
          REG_STEP_Y: regs.step_y      = cfg_data_i[23:0];
          REG_WIDTH:  regs.blit_width  = cfg_data_i[12:0];
          REG_HEIGHT: regs.blit_height = cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (push_i && !full_i) blit_pixel(in_data_i);
      if (pop_i && !empty_i) begin
        results_seen++;
        if (predicted_writes.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: result %0d arrived with nothing outstanding: %h",
                     $realtime, results_seen, out_data_i);
        end else begin
          want = predicted_writes.pop_front();
          bad  = "";
          if (out_data_i.out_pixel !== want.out_pixel) bad = {bad, " out_pixel"};
          if (out_data_i.next_src_col !== want.next_src_col) bad = {bad, " next_src_col"};
          if (out_data_i.next_src_row !== want.next_src_row) bad = {bad, " next_src_row"};
          if (out_data_i.row_end !== want.row_end) bad = {bad, " row_end"};
          if (out_data_i.blit_end !== want.blit_end) bad = {bad, " blit_end"};
          if (bad != "") begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: result %0d wrong in%s", $realtime, results_seen, bad);
              $display("  expected px %h col %0d row %0d re %b be %b",
                       want.out_pixel, want.next_src_col, want.next_src_row,
                       want.row_end, want.blit_end);
              $display("  got      px %h col %0d row %0d re %b be %b",
                       out_data_i.out_pixel, out_data_i.next_src_col,
                       out_data_i.next_src_row, out_data_i.row_end, out_data_i.blit_end);
            end
          end
        end
      end
    end
    pending_o = predicted_writes.size();
  end

endmodule

>>> verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tab_pkg::*;

  // run shape: a directed warm-up, then random phases of pixel beats,
  // each phase with its own register settings and idling pattern
  localparam int CYCLE_LIMIT = 200_000;
  localparam int PHASES      = 15;
  localparam int PHASE_BEATS = 60;
  localparam int DRAIN_WAIT  = 10;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_POP, IDLE_BOTH} idle_mode_e;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 push      = 1'b0;
  logic                 full;
  in_t                  in_data   = '0;
  logic                 empty;
  logic                 pop       = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;

  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int cycle_count   = 0;
  int fail_count;
  int pending;

  always #5 clk = ~clk;

  tinted_alpha_blit_engine dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  tab_blit_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push_i       (push),
    .full_i       (full),
    .in_data_i    (in_data),
    .empty_i      (empty),
    .pop_i        (pop),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // result side: pop is re-rolled every falling edge, so stalls land on
  // every phase of the pipeline; with no stall it stays high
  always @(negedge clk) begin
    pop <= ($urandom_range(0, 99) >= pop_stall_pct);
  end

  // watchdog, far above the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** tinted_alpha_blit_engine: FAILED **");
      $finish;
    end
  end

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 68; pop_stall_pct = 0;  end
      IDLE_POP:  begin send_idle_pct = 0;  pop_stall_pct = 68; end
      default:   begin send_idle_pct = 29; pop_stall_pct = 29; end
    endcase
  endtask

  // one input beat; entered and left at a falling edge, push left high so
  // back-to-back beats never see push dropped and raised in one step
  task automatic send_item(in_t beat);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // stop pushing, wait for every predicted beat to come back, then let the
  // pipeline settle before anyone touches the registers
  task automatic settle();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic program_regs(cfg_t c);
    write_reg(REG_TINT,   c.tint_color);
    write_reg(REG_STEP_X, {8'b0, c.step_x});
    write_reg(REG_STEP_Y, {8'b0, c.step_y});
    write_reg(REG_WIDTH,  {19'b0, c.blit_width});
    write_reg(REG_HEIGHT, {19'b0, c.blit_height});
    cfg_valid <= 1'b0;
  endtask

  function automatic in_t make_beat(logic op, logic [31:0] s, logic [31:0] d);
    in_t b;
    b.opcode    = op;
    b.src_pixel = s;
    b.dst_pixel = d;
    return b;
  endfunction

  // random pixel, alpha pulled toward the rounding edge and the extremes
  function automatic in_t random_pixel();
    in_t b;
    b = make_beat(OP_PIXEL, $urandom, $urandom);
    case ($urandom_range(0, 9))
      0: b.src_pixel[31:24] = 8'h00;
      1: b.src_pixel[31:24] = 8'h7F;
      2: b.src_pixel[31:24] = 8'h80;
      3: b.src_pixel[31:24] = 8'hFF;
      4: begin b.src_pixel = '1; b.dst_pixel = '0; end
      5: begin b.src_pixel = '0; b.dst_pixel = '1; end
      default: ;
    endcase
    return b;
  endfunction

  function automatic logic [31:0] pick_tint();
    case ($urandom_range(0, 5))
      0: return TINT_OFF;
      1: return 32'h0;
      2: return 32'hFFFF_FF00;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] pick_step();
    case ($urandom_range(0, 7))
      0: return 24'h0;
      1: return 24'h1;
      2: return 24'h01_0000;
      3: return 24'hFF_FFFF;
      4: return 24'($urandom);
      default: return 24'($urandom_range(1, 24'h03_0000));
    endcase
  endfunction

  // mostly small blits so rows and blits close often within a phase
  function automatic logic [12:0] pick_dim();
    case ($urandom_range(0, 11))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd4096;
      3: return 13'd8191;
      4: return 13'($urandom_range(7, 24));
      default: return 13'($urandom_range(2, 6));
    endcase
  endfunction

  // first phases pin the extremes, later ones draw at random
  function automatic cfg_t phase_settings(int p);
    cfg_t c;
    c.tint_color  = pick_tint();
    c.step_x      = pick_step();
    c.step_y      = pick_step();
    c.blit_width  = pick_dim();
    c.blit_height = pick_dim();
    case (p)
      0: c = '{tint_color: 32'h0, step_x: 24'hFF_FFFF, step_y: 24'hFF_FFFF,
               blit_width: 13'd4096, blit_height: 13'd4096};
      1: c = '{tint_color: TINT_OFF, step_x: 24'h1, step_y: 24'h1,
               blit_width: 13'd1, blit_height: 13'd1};
      2: c = '{tint_color: c.tint_color, step_x: 24'h0, step_y: 24'h0,
               blit_width: 13'd0, blit_height: 13'd8191};
      // column accumulator runs into saturation inside one row
      3: c = '{tint_color: c.tint_color, step_x: 24'hFF_FFFF, step_y: 24'h01_0000,
               blit_width: 13'd20, blit_height: 13'd3};
      // source row runs into saturation at the sixteenth row end
      4: c = '{tint_color: c.tint_color, step_x: 24'h00_8000, step_y: 24'hFF_FFFF,
               blit_width: 13'd2, blit_height: 13'd40};
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    // reset held low from time zero, released once and never again
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset registers, tint off, every pixel closes a 1x1 blit
    set_idling(IDLE_NONE);
    send_item(make_beat(OP_START, 32'hDEAD_BEEF, 32'h1234_5678));
    send_item(make_beat(OP_PIXEL, 32'hFF12_3456, 32'h00AB_CDEF));  // opaque source
    send_item(make_beat(OP_PIXEL, 32'h00FF_FFFF, 32'h1234_5678));  // fully clear source
    send_item(make_beat(OP_PIXEL, 32'h7F80_8080, 32'hFFFF_FFFF));  // just under round-up
    send_item(make_beat(OP_PIXEL, 32'h80FF_00FF, 32'h00FF_00FF));  // alpha rounds up
    send_item(make_beat(OP_PIXEL, 32'hFFFF_FFFF, 32'h0000_0000));
    send_item(make_beat(OP_PIXEL, 32'h0000_0000, 32'hFFFF_FFFF));
    settle();

    // directed: tint on with blue at full byte, fractional steps, 3x2 blit,
    // then a pixel past the blit end with no fresh start
    program_regs('{tint_color: 32'h00FF_80FF, step_x: 24'h01_8000, step_y: 24'hFF_FFFF,
                   blit_width: 13'd3, blit_height: 13'd2});
    send_item(make_beat(OP_START, 32'h0, 32'h0));
    for (int n = 0; n < 7; n++) send_item(random_pixel());
    settle();

    // directed: tint of zero, zero steps and zero sizes
    program_regs('{tint_color: 32'h0, step_x: 24'h0, step_y: 24'h0,
                   blit_width: 13'd0, blit_height: 13'd0});
    send_item(make_beat(OP_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(make_beat(OP_PIXEL, 32'hFFFF_FFFF, 32'h0));
    send_item(make_beat(OP_PIXEL, 32'h80FF_FFFF, 32'hFFFF_FFFF));
    settle();

    // random phases; idling pattern rotates through the four modes from phase to phase
    for (int p = 0; p < PHASES; p++) begin
      set_idling(idle_mode_e'(p % 4));
      program_regs(phase_settings(p));
      // some later phases carry on from the previous position without a start
      if (!(p >= 5 && p % 3 == 2))
        send_item(make_beat(OP_START, $urandom, $urandom));
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (p >= 5 && $urandom_range(0, 99) < 4)
          send_item(make_beat(OP_START, $urandom, $urandom));
        else
          send_item(random_pixel());
      end
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("** tinted_alpha_blit_engine: PASSED **");
    end else begin
      $display("** tinted_alpha_blit_engine: FAILED **");
    end
    $finish;
  end

endmodule
